// File: design/ltmds_pkg.sv
// Package for the limb-to-modular-digit splitter.
// Holds the word types, register indexes and controller/datapath links.
// No dependencies.
package ltmds_pkg;

  localparam int unsigned LIMB_W  = 64;
  localparam int unsigned RES_W   = 62;
  localparam int unsigned DBITS_W = 6;
  localparam int unsigned DCNT_W  = 7;
  localparam int unsigned CIDX_W  = 2;
  // One limb plus leftover bits from the previous limb.
  localparam int unsigned BUF_W   = 2 * LIMB_W;
  localparam int unsigned TOT_W   = 7;

  localparam logic [CIDX_W-1:0] CFG_DIGIT_BITS  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_DIGIT_COUNT = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_MODULUS_ONE = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_MODULUS_TWO = 2'd3;

  localparam logic [DBITS_W-1:0] DIGIT_BITS_RST  = 6'd16;
  localparam logic [DCNT_W-1:0]  DIGIT_COUNT_RST = 7'd64;
  localparam logic [RES_W-1:0]   MODULUS_RST     = 62'd4179340454199820289;

  typedef struct packed {
    logic [LIMB_W-1:0] limb;
    logic              negative;
    logic              last_limb;
    logic              zero_value;
  } in_word_t;

  typedef struct packed {
    logic [RES_W-1:0] residue_one;
    logic [RES_W-1:0] residue_two;
    logic             last_digit;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic can_emit;
    logic out_free;
  } dp_status_t;

endpackage

// File: design/ltmds_ctrl.sv
// Controller of the limb splitter: takes one limb word, steps out its digits,
// then closes the limb. Depends on ltmds_pkg.
module ltmds_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  ltmds_pkg::dp_status_t  status_i,
  output ltmds_pkg::dp_cmd_t     cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.can_emit) begin
          // hold while the output register is still full
          cmd_o.step = status_i.out_free;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: design/ltmds_dp.sv
// Datapath of the limb splitter: bit buffer, digit cut, modular residues and
// output register. Depends on ltmds_pkg.
module ltmds_dp #(
  parameter int unsigned MAX_DIGITS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ltmds_pkg::dp_cmd_t                  cmd_i,
  output ltmds_pkg::dp_status_t               status_o,
  input  ltmds_pkg::in_word_t                 in_data_i,
  input  logic [ltmds_pkg::DBITS_W-1:0]       digit_bits_i,
  input  logic [ltmds_pkg::DCNT_W-1:0]        digit_count_i,
  input  logic [ltmds_pkg::RES_W-1:0]         modulus_one_i,
  input  logic [ltmds_pkg::RES_W-1:0]         modulus_two_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ltmds_pkg::out_word_t                out_data_o
);

  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int unsigned LW    = ltmds_pkg::LIMB_W;
  localparam int unsigned BW    = ltmds_pkg::BUF_W;
  localparam int unsigned TW    = ltmds_pkg::TOT_W;
  localparam int unsigned RW    = ltmds_pkg::RES_W;
  localparam int unsigned DW    = ltmds_pkg::DBITS_W;
  localparam int unsigned CW    = ltmds_pkg::DCNT_W;

  logic [BW-1:0]    buf_q;
  logic [TW-1:0]    tot_q;    // valid bits in buf_q
  logic [TW-1:0]    pcnt_q;   // low bits of buf_q that came from earlier limbs
  logic [CNT_W-1:0] emit_q;
  logic             neg_q, last_q, zero_q;
  logic             out_valid_q;
  ltmds_pkg::out_word_t out_q;

  logic [DW-1:0]    m;
  logic [TW-1:0]    m_ext;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] emit_nx;
  logic             count_done;
  logic [LW-2:0]    dmask;
  logic [LW-2:0]    digit;
  logic [RW-1:0]    d_res;
  logic             neg_eff;
  logic [LW-1:0]    pmask;

  assign m     = (digit_bits_i == '0) ? DW'(1) : digit_bits_i;
  assign m_ext = TW'(m);

  always_comb begin
    if (digit_count_i == '0) begin
      k = CNT_W'(1);
    end else if (digit_count_i > CW'(MAX_DIGITS)) begin
      k = CNT_W'(MAX_DIGITS);
    end else begin
      k = CNT_W'(digit_count_i);
    end
  end

  assign emit_nx    = emit_q + CNT_W'(1);
  assign count_done = (emit_q >= k);

  assign status_o.can_emit = !count_done && (zero_q || last_q || (tot_q >= m_ext));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Cut the low m bits; a zero coefficient gives plain zero digits.
  assign dmask   = ~({(LW-1){1'b1}} << m);
  assign digit   = zero_q ? '0 : (buf_q[LW-2:0] & dmask);
  assign d_res   = digit[RW-1:0];
  assign neg_eff = neg_q && !zero_q;
  assign pmask   = ~({LW{1'b1}} << pcnt_q[DW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q       <= '0;
      tot_q       <= '0;
      pcnt_q      <= '0;
      emit_q      <= '0;
      neg_q       <= 1'b0;
      last_q      <= 1'b0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        neg_q  <= in_data_i.negative;
        last_q <= in_data_i.last_limb;
        zero_q <= in_data_i.zero_value;
        if (!in_data_i.zero_value) begin
          // join the new limb above the leftover bits
          buf_q  <= {{LW{1'b0}}, buf_q[LW-1:0]}
                  | ({{LW{1'b0}}, in_data_i.limb} << tot_q[DW-1:0]);
          tot_q  <= tot_q + TW'(LW);
          pcnt_q <= tot_q;
        end
      end
      if (cmd_i.step) begin
        buf_q       <= buf_q >> m;
        tot_q       <= (tot_q >= m_ext) ? (tot_q - m_ext) : '0;
        pcnt_q      <= (pcnt_q >= m_ext) ? (pcnt_q - m_ext) : '0;
        emit_q      <= emit_nx;
        out_valid_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        if (last_q || zero_q) begin
          buf_q  <= '0;
          tot_q  <= '0;
          pcnt_q <= '0;
          emit_q <= '0;
        end else if (count_done) begin
          // drop the unused limb bits, keep the older leftover
          buf_q <= {{LW{1'b0}}, buf_q[LW-1:0] & pmask};
          tot_q <= pcnt_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      out_q.residue_one <= neg_eff ? (modulus_one_i - d_res) : d_res;
      out_q.residue_two <= neg_eff ? (modulus_two_i - d_res) : d_res;
      out_q.last_digit  <= (emit_nx == k);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: design/limb_to_modular_digit_splitter.sv
// Limb-to-modular-digit splitter: cuts a signed multiprecision coefficient,
// fed as 64-bit limb words, into digits given as two modular residues.
// The first digit word of a limb is cut in the emit state that follows accept and
// is then held in the output register. Throughput: a limb word is closed before the
// next is taken; one digit per cycle while the output register is free, out of the shared shift-and-subtract datapath.
// Reset clears the leftover bits and counters and loads the register defaults.
module limb_to_modular_digit_splitter #(
  parameter int unsigned MAX_DIGITS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  ltmds_pkg::in_word_t                in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output ltmds_pkg::out_word_t               out_data_o,
  input  logic                               cfg_we_i,
  input  logic [ltmds_pkg::CIDX_W-1:0]       cfg_idx_i,
  input  logic [ltmds_pkg::RES_W-1:0]        cfg_wdata_i
);

  logic [ltmds_pkg::DBITS_W-1:0] digit_bits_q;
  logic [ltmds_pkg::DCNT_W-1:0]  digit_count_q;
  logic [ltmds_pkg::RES_W-1:0]   modulus_one_q;
  logic [ltmds_pkg::RES_W-1:0]   modulus_two_q;

  ltmds_pkg::dp_cmd_t    cmd;
  ltmds_pkg::dp_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_bits_q  <= ltmds_pkg::DIGIT_BITS_RST;
      digit_count_q <= ltmds_pkg::DIGIT_COUNT_RST;
      modulus_one_q <= ltmds_pkg::MODULUS_RST;
      modulus_two_q <= ltmds_pkg::MODULUS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ltmds_pkg::CFG_DIGIT_BITS:  digit_bits_q  <= cfg_wdata_i[ltmds_pkg::DBITS_W-1:0];
        ltmds_pkg::CFG_DIGIT_COUNT: digit_count_q <= cfg_wdata_i[ltmds_pkg::DCNT_W-1:0];
        ltmds_pkg::CFG_MODULUS_ONE: modulus_one_q <= cfg_wdata_i;
        ltmds_pkg::CFG_MODULUS_TWO: modulus_two_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ltmds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ltmds_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .in_data_i     (in_data_i),
    .digit_bits_i  (digit_bits_q),
    .digit_count_i (digit_count_q),
    .modulus_one_i (modulus_one_q),
    .modulus_two_i (modulus_two_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule

// File: tb/tb.sv
// Testbench for limb_to_modular_digit_splitter: a directed table, then random coefficients.
// Predicts the digit words in SystemVerilog and checks them as they come out.
// Depends on ltmds_pkg and the splitter RTL.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned LIMB_W  = ltmds_pkg::LIMB_W;
  localparam int unsigned RES_W   = ltmds_pkg::RES_W;
  localparam int unsigned DBITS_W = ltmds_pkg::DBITS_W;
  localparam int unsigned DCNT_W  = ltmds_pkg::DCNT_W;
  localparam int unsigned CIDX_W  = ltmds_pkg::CIDX_W;

  localparam int unsigned MAX_DIGITS   = 64;
  localparam int unsigned RAND_ITEMS   = 180;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned STALL_LIMIT  = 4000;

  typedef enum logic {ROW_WRITE, ROW_WORD} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [CIDX_W-1:0]   idx;
    logic [RES_W-1:0]    wdata;
    ltmds_pkg::in_word_t word;
    bit                  pinned;
    logic [RES_W-1:0]    pin_r1;
  } row_t;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  ltmds_pkg::in_word_t  in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  ltmds_pkg::out_word_t out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CIDX_W-1:0]    cfg_idx_i   = '0;
  logic [RES_W-1:0]     cfg_wdata_i = '0;

  // Register copies and carry state of the predictor
  logic [DBITS_W-1:0]  dig_bits  = ltmds_pkg::DIGIT_BITS_RST;
  logic [DCNT_W-1:0]   dig_count = ltmds_pkg::DIGIT_COUNT_RST;
  logic [RES_W-1:0]    mod_one   = ltmds_pkg::MODULUS_RST;
  logic [RES_W-1:0]    mod_two   = ltmds_pkg::MODULUS_RST;
  logic [LIMB_W-1:0]   carry_bits = '0;
  int unsigned         carry_cnt  = 0;
  int unsigned         digits_out = 0;

  ltmds_pkg::out_word_t due_digits[$];
  row_t                rows[$];
  int                  errors      = 0;
  int unsigned         rand_items  = 0;
  int unsigned         quiet_cycles = 0;
  int unsigned         stall_left  = 0;
  bit                  calm        = 1'b0;

  limb_to_modular_digit_splitter #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [LIMB_W-1:0] low_mask(input int unsigned n);
    if (n >= LIMB_W) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic int unsigned eff_bits();
    return (dig_bits == 0) ? 1 : 32'(dig_bits);
  endfunction

  function automatic int unsigned eff_count();
    if (dig_count == 0) return 1;
    if (dig_count > MAX_DIGITS) return MAX_DIGITS;
    return 32'(dig_count);
  endfunction

  function automatic void clear_carry();
    carry_bits = '0;
    carry_cnt  = 0;
    digits_out = 0;
  endfunction

  function automatic void queue_digit(input logic [LIMB_W-1:0] d, input logic neg,
                                      input int unsigned k);
    logic [LIMB_W-1:0]    r1, r2;
    ltmds_pkg::out_word_t w;
    r1 = d;
    r2 = d;
    if (neg) begin
      // wrap modulo 2^62, so a zero digit gives the modulus back
      r1 = {2'b00, mod_one} - d;
      r2 = {2'b00, mod_two} - d;
    end
    digits_out++;
    w.residue_one = r1[RES_W-1:0];
    w.residue_two = r2[RES_W-1:0];
    w.last_digit  = (digits_out == k);
    due_digits.push_back(w);
  endfunction

  // Cut one accepted limb word into the digit words it completes.
  function automatic void split_limb(input ltmds_pkg::in_word_t w);
    int unsigned       m, k, need, rem_n;
    logic [LIMB_W-1:0] rem, d;
    m = eff_bits();
    k = eff_count();
    if (w.zero_value) begin
      // plain zeros up to the count, never the moduli
      while (digits_out < k) queue_digit('0, 1'b0, k);
      clear_carry();
      return;
    end
    rem   = w.limb;
    rem_n = LIMB_W;
    while (digits_out < k) begin
      if (carry_cnt >= m) begin
        d          = carry_bits & low_mask(m);
        carry_bits = carry_bits >> m;
        carry_cnt -= m;
      end else begin
        need = m - carry_cnt;
        if (need > rem_n) begin
          // hold what is left of the limb for the next word
          carry_bits |= rem << carry_cnt;
          carry_cnt  += rem_n;
          break;
        end
        d          = carry_bits | ((rem & low_mask(need)) << carry_cnt);
        rem        = rem >> need;
        rem_n     -= need;
        carry_bits = '0;
        carry_cnt  = 0;
      end
      queue_digit(d, w.negative, k);
    end
    if (w.last_limb) begin
      while (digits_out < k) begin
        d          = carry_bits & low_mask(m);
        carry_bits = carry_bits >> m;
        queue_digit(d, w.negative, k);
      end
      clear_carry();
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [RES_W-1:0] wide62();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[RES_W-1:0];
  endfunction

  function automatic logic [LIMB_W-1:0] rand_limb();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic row_t word_row(input logic [LIMB_W-1:0] limb, input logic neg,
                                    input logic last, input logic zero,
                                    input bit pinned, input logic [RES_W-1:0] r1);
    row_t r;
    r.kind            = ROW_WORD;
    r.idx             = '0;
    r.wdata           = '0;
    r.word.limb       = limb;
    r.word.negative   = neg;
    r.word.last_limb  = last;
    r.word.zero_value = zero;
    r.pinned          = pinned;
    r.pin_r1          = r1;
    return r;
  endfunction

  function automatic row_t write_row(input logic [CIDX_W-1:0] idx,
                                     input logic [RES_W-1:0] v);
    row_t r;
    r        = word_row('0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    r.kind   = ROW_WRITE;
    r.idx    = idx;
    r.wdata  = v;
    return r;
  endfunction

  task automatic drive_limb(input ltmds_pkg::in_word_t w, input bit pinned,
                            input logic [RES_W-1:0] pin_r1);
    int unsigned gap, base;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    base = due_digits.size();
    split_limb(w);
    if (pinned && (due_digits.size() == base || due_digits[base].residue_one != pin_r1)) begin
      $error("residue_one of first digit: expected %h, predicted %h", pin_r1,
             (due_digits.size() == base) ? '0 : due_digits[base].residue_one);
      errors++;
    end
  endtask

  // Drop valid and wait until every digit word has come and the block has settled.
  task automatic drain_to_idle();
    in_valid_i <= 1'b0;
    while (due_digits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [RES_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      ltmds_pkg::CFG_DIGIT_BITS:  dig_bits  = v[DBITS_W-1:0];
      ltmds_pkg::CFG_DIGIT_COUNT: dig_count = v[DCNT_W-1:0];
      ltmds_pkg::CFG_MODULUS_ONE: mod_one   = v;
      ltmds_pkg::CFG_MODULUS_TWO: mod_two   = v;
      default: ;
    endcase
  endtask

  task automatic random_config();
    logic [RES_W-1:0] v;
    if ($urandom_range(3) != 0) begin
      v = $urandom_range(1) ? wide62() : '0;
      case ($urandom_range(9))
        0:       v[DBITS_W-1:0] = 6'd0;
        1:       v[DBITS_W-1:0] = 6'd1;
        2:       v[DBITS_W-1:0] = 6'd63;
        default: v[DBITS_W-1:0] = DBITS_W'($urandom_range(1, 63));
      endcase
      write_reg(ltmds_pkg::CFG_DIGIT_BITS, v);
    end
    if ($urandom_range(3) != 0) begin
      v = $urandom_range(1) ? wide62() : '0;
      case ($urandom_range(9))
        0:          v[DCNT_W-1:0] = 7'd0;
        1:          v[DCNT_W-1:0] = 7'd64;
        2:          v[DCNT_W-1:0] = DCNT_W'($urandom_range(65, 127));
        3, 4, 5:    v[DCNT_W-1:0] = DCNT_W'($urandom_range(1, 4));
        default:    v[DCNT_W-1:0] = DCNT_W'($urandom_range(1, 16));
      endcase
      write_reg(ltmds_pkg::CFG_DIGIT_COUNT, v);
    end
    for (int unsigned i = 0; i < 2; i++) begin
      if ($urandom_range(2) != 0) begin
        case ($urandom_range(9))
          0:       v = RES_W'($urandom_range(1));
          1:       v = '1;
          2:       v = ltmds_pkg::MODULUS_RST;
          default: v = wide62();
        endcase
        write_reg((i == 0) ? ltmds_pkg::CFG_MODULUS_ONE : ltmds_pkg::CFG_MODULUS_TWO, v);
      end
    end
  endtask

  // One coefficient: mostly well-formed limb runs, some with mixed signs or a zero mark.
  task automatic send_coefficient();
    int unsigned         m, k, need_limbs, limbs, shape, i;
    bit                  neg;
    ltmds_pkg::in_word_t w;
    m          = eff_bits();
    k          = eff_count();
    need_limbs = (k * m + 63) / 64;
    limbs      = $urandom_range(1, need_limbs + 1);
    if (limbs > 6) limbs = $urandom_range(4, 6);
    shape = $urandom_range(99);
    if (shape >= 96) limbs = 1;
    neg = 1'($urandom_range(1));
    for (i = 0; i < limbs; i++) begin
      w.limb       = rand_limb();
      w.negative   = (shape < 10) ? 1'($urandom_range(1)) : neg;
      w.last_limb  = (i == limbs - 1);
      w.zero_value = 1'b0;
      if (shape >= 90 && i == limbs - 1) begin
        w.zero_value = 1'b1;
        w.last_limb  = 1'($urandom_range(1));
      end
      drive_limb(w, 1'b0, '0);
      rand_items++;
    end
  endtask

  // Receiver: random stalls, none while calm.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(3) == 0) begin
      stall_left  <= pick_gap();
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    ltmds_pkg::out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_digits.size() == 0) begin
        $error("unexpected digit word %h", out_data_o);
        errors++;
      end else begin
        want = due_digits.pop_front();
        if (out_data_o.residue_one !== want.residue_one) begin
          $error("residue_one: expected %h, got %h", want.residue_one, out_data_o.residue_one);
          errors++;
        end
        if (out_data_o.residue_two !== want.residue_two) begin
          $error("residue_two: expected %h, got %h", want.residue_two, out_data_o.residue_two);
          errors++;
        end
        if (out_data_o.last_digit !== want.last_digit) begin
          $error("last_digit: expected %b, got %b", want.last_digit, out_data_o.last_digit);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no word moves on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("limb_to_modular_digit_splitter verification failed");
      $finish;
    end
  end

  initial begin
    // reset defaults: 16-bit digits, 64 per coefficient
    rows.push_back(word_row(64'hDEAD_BEEF_0BAD_F00D, 1'b0, 1'b0, 1'b1, 1'b1, '0));
    rows.push_back(word_row('1, 1'b0, 1'b1, 1'b0, 1'b1, 62'hFFFF));
    rows.push_back(word_row(64'd1, 1'b1, 1'b1, 1'b0, 1'b1, ltmds_pkg::MODULUS_RST - 62'd1));
    rows.push_back(write_row(ltmds_pkg::CFG_DIGIT_COUNT, 62'd4));
    rows.push_back(word_row('0, 1'b1, 1'b1, 1'b0, 1'b1, ltmds_pkg::MODULUS_RST));
    // count reached mid-coefficient, the last limb then only clears
    rows.push_back(word_row(64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 1'b0, 1'b1, 62'hCDEF));
    rows.push_back(word_row('1, 1'b1, 1'b1, 1'b0, 1'b0, '0));
    // widest digits, count above the maximum
    rows.push_back(write_row(ltmds_pkg::CFG_DIGIT_BITS, 62'd63));
    rows.push_back(write_row(ltmds_pkg::CFG_DIGIT_COUNT, 62'd127));
    rows.push_back(word_row('1, 1'b0, 1'b1, 1'b0, 1'b1, 62'h3FFF_FFFF_FFFF_FFFF));
    rows.push_back(word_row('1, 1'b1, 1'b1, 1'b0, 1'b1, ltmds_pkg::MODULUS_RST + 62'd1));
    // zero width and zero count, moduli at the extremes
    rows.push_back(write_row(ltmds_pkg::CFG_DIGIT_BITS, 62'd0));
    rows.push_back(write_row(ltmds_pkg::CFG_DIGIT_COUNT, 62'd0));
    rows.push_back(write_row(ltmds_pkg::CFG_MODULUS_ONE, 62'd0));
    rows.push_back(write_row(ltmds_pkg::CFG_MODULUS_TWO, 62'h3FFF_FFFF_FFFF_FFFF));
    rows.push_back(word_row(64'd1, 1'b1, 1'b1, 1'b0, 1'b1, 62'h3FFF_FFFF_FFFF_FFFF));
    rows.push_back(word_row('0, 1'b1, 1'b1, 1'b0, 1'b1, 62'd0));
    rows.push_back(write_row(ltmds_pkg::CFG_MODULUS_ONE, 62'd1));
    rows.push_back(write_row(ltmds_pkg::CFG_MODULUS_TWO, 62'd2));
    rows.push_back(write_row(ltmds_pkg::CFG_DIGIT_BITS, 62'd40));
    rows.push_back(write_row(ltmds_pkg::CFG_DIGIT_COUNT, 62'd3));
    rows.push_back(word_row('1, 1'b1, 1'b0, 1'b0, 1'b1, 62'h3FFF_FF00_0000_0002));
    rows.push_back(word_row(64'h8000_0000_0000_0001, 1'b1, 1'b1, 1'b0, 1'b0, '0));
    // shrink the digit width between two limbs of one coefficient
    rows.push_back(write_row(ltmds_pkg::CFG_DIGIT_COUNT, 62'd64));
    rows.push_back(word_row(64'h0F1E_2D3C_4B5A_6978, 1'b0, 1'b0, 1'b0, 1'b1,
                            62'h3C_4B5A_6978));
    rows.push_back(write_row(ltmds_pkg::CFG_DIGIT_BITS, 62'd8));
    rows.push_back(word_row(64'hFEDC_BA98_7654_3210, 1'b0, 1'b1, 1'b0, 1'b1, 62'h2D));
    // zero mark in the middle of a coefficient
    rows.push_back(write_row(ltmds_pkg::CFG_DIGIT_BITS, 62'd20));
    rows.push_back(write_row(ltmds_pkg::CFG_DIGIT_COUNT, 62'd5));
    rows.push_back(word_row('1, 1'b1, 1'b0, 1'b0, 1'b1, 62'h3FFF_FFFF_FFF0_0002));
    rows.push_back(word_row(64'hFFFF_0000_FFFF_0000, 1'b1, 1'b0, 1'b1, 1'b1, 62'd0));
    // sign taken from the word that completes each digit
    rows.push_back(word_row(64'h1234_5678_9ABC_DEF0, 1'b0, 1'b0, 1'b0, 1'b1, 62'hCDEF0));
    rows.push_back(word_row(64'h0FED_CBA9_8765_4321, 1'b1, 1'b1, 1'b0, 1'b0, '0));
    rows.push_back(write_row(ltmds_pkg::CFG_DIGIT_BITS, 62'd1));
    rows.push_back(write_row(ltmds_pkg::CFG_DIGIT_COUNT, 62'd64));
    rows.push_back(word_row(64'hA5A5_A5A5_A5A5_A5A5, 1'b0, 1'b1, 1'b0, 1'b1, 62'd1));
    rows.push_back(word_row('1, 1'b1, 1'b0, 1'b0, 1'b1, 62'd0));
    rows.push_back(word_row(64'h5A5A_5A5A_5A5A_5A5A, 1'b0, 1'b1, 1'b0, 1'b0, '0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WRITE) begin
        drain_to_idle();
        write_reg(rows[i].idx, rows[i].wdata);
      end else begin
        drive_limb(rows[i].word, rows[i].pinned, rows[i].pin_r1);
      end
    end

    // each phase starts from an empty pipe, then new settings
    while (rand_items < RAND_ITEMS) begin
      drain_to_idle();
      random_config();
      calm = ($urandom_range(4) == 0);
      repeat ($urandom_range(2, 6)) send_coefficient();
    end

    calm = 1'b0;
    drain_to_idle();
    if (errors == 0) begin
      $display("limb_to_modular_digit_splitter verification clean");
    end else begin
      $display("limb_to_modular_digit_splitter verification failed");
    end
    $finish;
  end

endmodule
